// ===== src/blao_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blao_pkg
// Shared types and constants of the band-limited additive oscillator.
// ----------------------------------------------------------------------------
package blao_pkg;

    // Default build parameters
    localparam int DEF_MAX_HARMONICS   = 64;
    localparam int DEF_PHASE_BITS      = 16;
    localparam int DEF_SINE_TABLE_BITS = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_LENGTH  = 3'd5;

    // Waveform codes
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SAW    = 2'd2;
    localparam logic [1:0] WAVE_UNUSED = 2'd3;

    // Register reset values
    localparam logic [15:0] RST_TONE_FREQ   = 16'd440;
    localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
    localparam logic [23:0] RST_AMPLITUDE   = 24'd1048576;

    // Fixed datapath widths
    localparam int FN_W  = 48;   // frequency times sample index
    localparam int FS_W  = 18;   // sample rate
    localparam int DIV_W = 25;   // magnitude of one scaled term
    localparam int CNT_W = 6;    // step counter, covers FN_W steps

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_INIT,
        S_HCHK,
        S_PHASE,
        S_ROM,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_ACC,
        S_SAT
    } t_state;

endpackage

// ===== src/band_limited_additive_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_limited_additive_oscillator
// Adds a band-limited sine, square or sawtooth tone to a stereo mix sample.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one sample; busy then stays high
// until the result is ready, and the result shows on o_left_out/o_right_out
// for exactly one cycle with o_valid, which cannot be held off. A sample
// outside the tone window (or with waveform code 3 or sample rate 0) goes
// straight from idle to the saturation state. Inside the window the block first
// reduces f*n modulo the sample rate, one bit a cycle, then runs one
// harmonic at a time through a shared bit-serial phase divider, the quarter
// wave ROM, one multiplier and a bit-serial divide by the harmonic number,
// for each of H harmonics (H = 1 for sine).
module band_limited_additive_oscillator #(
    parameter int MAX_HARMONICS   = blao_pkg::DEF_MAX_HARMONICS,
    parameter int PHASE_BITS      = blao_pkg::DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = blao_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [blao_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [blao_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       i_sample_index,
    input  logic signed [31:0]                i_left_in,
    input  logic signed [31:0]                i_right_in,
    output logic                              o_valid,
    output logic signed [31:0]                o_left_out,
    output logic signed [31:0]                o_right_out
);
    import blao_pkg::*;

    localparam int HW        = (MAX_HARMONICS > 1) ? $clog2(2 * MAX_HARMONICS) : 1;
    localparam int KW        = $clog2(MAX_HARMONICS + 2);
    localparam int HFW       = HW + 16;
    localparam int AW        = 26 + $clog2(MAX_HARMONICS);
    localparam int SW        = ((AW > 32) ? AW : 32) + 1;
    localparam int QBITS     = PHASE_BITS - 2;
    localparam int ROM_N     = 2 ** SINE_TABLE_BITS;
    localparam int ROM_DEPTH = ROM_N + 1;

    // Taylor series divisors (2i+2)(2i+3)
    localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic [14:0] t_rom [ROM_DEPTH];

    // Quarter-wave sine table, Q1.15, from a nine-term Taylor series in Q30
    function automatic t_rom build_rom();
        t_rom                   rom;
        longint unsigned        x;
        longint unsigned        x2;
        longint unsigned        term;
        longint                 sum;
        longint                 rnd;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            x    = (64'd1686629713 * longint'(k)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int i = 0; i < 8; i++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[i];
                if ((i % 2) == 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rnd = (sum + 16384) >>> 15;
            if (rnd > 32767) begin
                rnd = 32767;
            end
            rom[k] = 15'(rnd);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // Configuration registers
    logic [1:0]            r_wave;
    logic [15:0]           r_freq;
    logic [FS_W-1:0]       r_fs;
    logic [23:0]           r_amp;
    logic [31:0]           r_first;
    logic [31:0]           r_len;

    // Sequencer and datapath registers
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [FN_W-1:0]       r_fn, n_fn;
    logic [FS_W-1:0]       r_rem, n_rem;
    logic [FS_W-1:0]       r_res, n_res;
    logic [FS_W-1:0]       r_dstep, n_dstep;
    logic [FS_W-1:0]       r_prem, n_prem;
    logic [PHASE_BITS-1:0] r_q, n_q;
    logic [KW-1:0]         r_k, n_k;
    logic [HW-1:0]         r_h, n_h;
    logic [HFW-1:0]        r_hf, n_hf;
    logic [14:0]           r_sin;
    logic                  r_sneg;
    logic signed [40:0]    r_prod, n_prod;
    logic [DIV_W-1:0]      r_dvd, n_dvd;
    logic [HW-1:0]         r_drem, n_drem;
    logic                  r_tneg, n_tneg;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic signed [31:0]    r_left, n_left;
    logic signed [31:0]    r_right, n_right;
    logic signed [31:0]    r_lo, n_lo;
    logic signed [31:0]    r_ro, n_ro;
    logic                  r_valid, n_valid;

    // Shared combinational helpers
    logic                  w_active;
    logic                  w_stop;
    logic [FS_W:0]         w_fs_tmp;
    logic [FS_W:0]         w_fs_sub;
    logic                  w_fs_ge;
    logic [HW:0]           w_h_tmp;
    logic                  w_h_ge;
    logic [FS_W:0]         w_res_sum;
    logic [FS_W:0]         w_dbl;
    logic [QBITS+SINE_TABLE_BITS-1:0] w_idx_full;
    logic [SINE_TABLE_BITS-1:0]       w_idx;
    logic [SINE_TABLE_BITS:0]         w_addr;
    logic signed [15:0]    w_sval;
    logic [25:0]           w_t;
    logic [25:0]           w_tmag;
    logic [AW-1:0]         w_qext;
    logic signed [SW-1:0]  w_lsum;
    logic signed [SW-1:0]  w_rsum;
    logic signed [SW-1:0]  w_max;
    logic signed [SW-1:0]  w_min;

    // Tone window and validity of the current settings
    assign w_active = ((i_sample_index - r_first) < r_len) && (r_wave != WAVE_UNUSED)
                      && (r_fs != '0);

    // Stop test before each harmonic
    always_comb begin
        if (r_k > KW'(MAX_HARMONICS)) begin
            w_stop = 1'b1;
        end else if (r_wave == WAVE_SINE) begin
            w_stop = (r_k != KW'(1));
        end else begin
            w_stop = (r_hf > HFW'(r_fs >> 1));
        end
    end

    // Shared restoring step against the sample rate (modulo and phase)
    always_comb begin
        if (r_state == S_MOD) begin
            w_fs_tmp = {r_rem, r_fn[FN_W-1]};
        end else begin
            w_fs_tmp = {r_prem, 1'b0};
        end
        w_fs_ge  = (w_fs_tmp >= {1'b0, r_fs});
        w_fs_sub = w_fs_tmp - {1'b0, r_fs};
    end

    // Restoring step against the harmonic number
    assign w_h_tmp = {r_drem, r_dvd[DIV_W-1]};
    assign w_h_ge  = (w_h_tmp >= {1'b0, r_h});

    assign w_res_sum = {1'b0, r_res} + {1'b0, r_dstep};
    assign w_dbl     = {r_rem, 1'b0};

    // Phase to table address
    assign w_idx_full = {r_q[QBITS-1:0], {SINE_TABLE_BITS{1'b0}}} >> QBITS;
    assign w_idx      = w_idx_full[SINE_TABLE_BITS-1:0];
    assign w_addr     = r_q[QBITS] ? ((SINE_TABLE_BITS+1)'(ROM_N) - {1'b0, w_idx})
                                   : {1'b0, w_idx};

    assign w_sval = r_sneg ? -$signed({1'b0, r_sin}) : $signed({1'b0, r_sin});
    assign w_t    = r_prod[40:15];
    assign w_tmag = w_t[25] ? -w_t : w_t;
    assign w_qext = {{(AW-DIV_W){1'b0}}, r_dvd};

    // Saturating output sums
    assign w_lsum = {{(SW-32){r_left[31]}}, r_left} + {{(SW-AW){r_acc[AW-1]}}, r_acc};
    assign w_rsum = {{(SW-32){r_right[31]}}, r_right} + {{(SW-AW){r_acc[AW-1]}}, r_acc};
    assign w_max  = {{(SW-31){1'b0}}, {31{1'b1}}};
    assign w_min  = {{(SW-31){1'b1}}, {31{1'b0}}};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = w_active ? S_MOD : S_SAT;
                end
            end
            S_MOD: begin
                if (r_cnt == '0) begin
                    n_state = S_INIT;
                end
            end
            S_INIT:  n_state = S_HCHK;
            S_HCHK:  n_state = w_stop ? S_SAT : S_PHASE;
            S_PHASE: begin
                if (r_cnt == '0) begin
                    n_state = S_ROM;
                end
            end
            S_ROM:   n_state = S_MUL;
            S_MUL:   n_state = S_DIVI;
            S_DIVI:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:   n_state = S_HCHK;
            S_SAT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_cnt   = r_cnt;
        n_fn    = r_fn;
        n_rem   = r_rem;
        n_res   = r_res;
        n_dstep = r_dstep;
        n_prem  = r_prem;
        n_q     = r_q;
        n_k     = r_k;
        n_h     = r_h;
        n_hf    = r_hf;
        n_prod  = r_prod;
        n_dvd   = r_dvd;
        n_drem  = r_drem;
        n_tneg  = r_tneg;
        n_acc   = r_acc;
        n_left  = r_left;
        n_right = r_right;
        n_lo    = r_lo;
        n_ro    = r_ro;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                // capture the transaction
                if (start) begin
                    n_left  = i_left_in;
                    n_right = i_right_in;
                    n_fn    = {16'b0, i_sample_index} * {32'b0, r_freq};
                    n_rem   = '0;
                    n_acc   = '0;
                    n_cnt   = CNT_W'(FN_W - 1);
                end
            end
            S_MOD: begin
                // reduce f*n modulo the sample rate, one bit a cycle
                n_rem = w_fs_ge ? w_fs_sub[FS_W-1:0] : w_fs_tmp[FS_W-1:0];
                n_fn  = r_fn << 1;
                n_cnt = r_cnt - 1'b1;
            end
            S_INIT: begin
                // first harmonic and per-harmonic steps
                n_res = r_rem;
                n_k   = KW'(1);
                n_h   = HW'(1);
                n_hf  = HFW'(r_freq);
                if (r_wave == WAVE_SQUARE) begin
                    n_dstep = (w_dbl >= {1'b0, r_fs}) ? FS_W'(w_dbl - {1'b0, r_fs})
                                                      : w_dbl[FS_W-1:0];
                end else begin
                    n_dstep = r_rem;
                end
            end
            S_HCHK: begin
                n_prem = r_res;
                n_q    = '0;
                n_cnt  = CNT_W'(PHASE_BITS - 1);
            end
            S_PHASE: begin
                // phase = residue * 2^PHASE_BITS / fs, one bit a cycle
                n_prem = w_fs_ge ? w_fs_sub[FS_W-1:0] : w_fs_tmp[FS_W-1:0];
                n_q    = {r_q[PHASE_BITS-2:0], w_fs_ge};
                n_cnt  = r_cnt - 1'b1;
            end
            S_MUL: begin
                n_prod = $signed({1'b0, r_amp}) * w_sval;
            end
            S_DIVI: begin
                n_tneg = w_t[25];
                n_dvd  = w_tmag[DIV_W-1:0];
                n_drem = '0;
                n_cnt  = CNT_W'(DIV_W - 1);
            end
            S_DIV: begin
                // divide the term by h, one quotient bit a cycle
                n_drem = w_h_ge ? HW'(w_h_tmp - {1'b0, r_h}) : w_h_tmp[HW-1:0];
                n_dvd  = {r_dvd[DIV_W-2:0], w_h_ge};
                n_cnt  = r_cnt - 1'b1;
            end
            S_ACC: begin
                // add the term and advance to the next harmonic
                n_acc = r_tneg ? (r_acc - $signed(w_qext)) : (r_acc + $signed(w_qext));
                n_k   = r_k + 1'b1;
                if (r_wave == WAVE_SQUARE) begin
                    n_h  = r_h + HW'(2);
                    n_hf = r_hf + HFW'({r_freq, 1'b0});
                end else begin
                    n_h  = r_h + 1'b1;
                    n_hf = r_hf + HFW'(r_freq);
                end
                n_res = (w_res_sum >= {1'b0, r_fs}) ? FS_W'(w_res_sum - {1'b0, r_fs})
                                                    : w_res_sum[FS_W-1:0];
            end
            S_SAT: begin
                if (w_lsum > w_max) begin
                    n_lo = 32'sh7FFFFFFF;
                end else if (w_lsum < w_min) begin
                    n_lo = 32'sh80000000;
                end else begin
                    n_lo = w_lsum[31:0];
                end
                if (w_rsum > w_max) begin
                    n_ro = 32'sh7FFFFFFF;
                end else if (w_rsum < w_min) begin
                    n_ro = 32'sh80000000;
                end else begin
                    n_ro = w_rsum[31:0];
                end
                n_valid = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_left_out  = r_lo;
    assign o_right_out = r_ro;

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_wave  <= WAVE_SINE;
            r_freq  <= RST_TONE_FREQ;
            r_fs    <= RST_SAMPLE_RATE;
            r_amp   <= RST_AMPLITUDE;
            r_first <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WAVEFORM:     r_wave  <= i_cfg_data[1:0];
                    CFG_TONE_FREQ:    r_freq  <= i_cfg_data[15:0];
                    CFG_SAMPLE_RATE:  r_fs    <= i_cfg_data[FS_W-1:0];
                    CFG_AMPLITUDE:    r_amp   <= i_cfg_data[23:0];
                    CFG_FIRST_SAMPLE: r_first <= i_cfg_data;
                    CFG_TONE_LENGTH:  r_len   <= i_cfg_data;
                    default: begin
                        r_len <= r_len;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_fn    <= n_fn;
        r_rem   <= n_rem;
        r_res   <= n_res;
        r_dstep <= n_dstep;
        r_prem  <= n_prem;
        r_q     <= n_q;
        r_k     <= n_k;
        r_h     <= n_h;
        r_hf    <= n_hf;
        r_prod  <= n_prod;
        r_dvd   <= n_dvd;
        r_drem  <= n_drem;
        r_tneg  <= n_tneg;
        r_acc   <= n_acc;
        r_left  <= n_left;
        r_right <= n_right;
        r_lo    <= n_lo;
        r_ro    <= n_ro;
    end

    // Sine table read, registered
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROM) begin
            r_sin  <= SINE_ROM[w_addr];
            r_sneg <= r_q[PHASE_BITS-1];
        end
    end

`ifndef SYNTHESIS
    // A result never overlaps a transaction in progress
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but block not busy");

    // The result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A result follows only the end of a transaction
    a_valid_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result strobe without a transaction");
`endif

endmodule

// ===== verif/tb_band_limited_additive_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_band_limited_additive_oscillator
// Self-checking bench for the band-limited additive oscillator. A directed
// table covers pass-through, window edges, every waveform and saturation.
// Random phases follow, each with new register settings. Every result is
// checked against a typed expectation or a bit-exact tone predictor in the bench.
// ----------------------------------------------------------------------------
module tb_band_limited_additive_oscillator;
    import blao_pkg::*;

    localparam int  ROM_LEN     = 1 << DEF_SINE_TABLE_BITS;
    localparam int  N_PHASES    = 12;
    localparam int  PHASE_ITEMS = 136;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [31:0] n;
        logic [31:0] l;
        logic [31:0] r;
        bit          typed;
        logic [31:0] el;
        logic [31:0] er;
    } t_row;

    typedef struct {
        logic [31:0] l;
        logic [31:0] r;
    } t_mix;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [31:0] i_cfg_data = '0;
    logic        start      = 1'b0;
    logic        busy;
    logic [31:0] i_sample_index = '0;
    logic signed [31:0] i_left_in  = '0;
    logic signed [31:0] i_right_in = '0;
    logic        o_valid;
    logic signed [31:0] o_left_out;
    logic signed [31:0] o_right_out;

    // Typed expectation travelling with the driven transaction
    bit          fixed_exp = 1'b0;
    t_mix        fixed_mix;

    // Shadow registers
    logic [1:0]  wave_sh;
    logic [15:0] freq_sh;
    logic [17:0] rate_sh;
    logic [23:0] amp_sh;
    logic [31:0] first_sh;
    logic [31:0] length_sh;

    int          quarter_sine [0:ROM_LEN];
    t_mix        pending_mix [$];
    t_row        directed [$];
    int          errors = 0;
    longint      cycles = 0;

    band_limited_additive_oscillator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_sample_index (i_sample_index),
        .i_left_in      (i_left_in),
        .i_right_in     (i_right_in),
        .o_valid        (o_valid),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    always #6 i_clk = ~i_clk;

    // Quarter-wave Q1.15 entry from a Q30 Taylor series
    function automatic int sine_entry(int k);
        longint unsigned x, x2, term;
        longint          acc;
        longint          q;
        x    = (64'd1686629713 * longint'(k)) >> DEF_SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int i = 0; i < 8; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i + 2) * (2 * i + 3));
            if ((i & 1) == 0) acc = acc - longint'(term);
            else              acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        q = (acc + 16384) >>> 15;
        if (q > 32767) q = 32767;
        return int'(q);
    endfunction

    // One harmonic: exact phase, ROM lookup, gain, divide by h
    function automatic longint harmonic(longint h, logic [31:0] n);
        longint unsigned rem, ph;
        int              quad, idx, s;
        longint          p, t;
        rem  = (longint'(h) * longint'(freq_sh) * longint'(n)) % longint'(rate_sh);
        ph   = ((rem << DEF_PHASE_BITS) / longint'(rate_sh)) & 64'hFFFF;
        quad = int'(ph >> 14) & 3;
        idx  = int'((ph & 64'h3FFF) >> 4) & (ROM_LEN - 1);
        s    = (quad & 1) ? quarter_sine[ROM_LEN - idx] : quarter_sine[idx];
        if (quad & 2) s = -s;
        p = longint'(amp_sh) * longint'(s);
        if (p >= 0) t = p >>> 15;
        else        t = -((-p + 32767) >>> 15);
        return t / h;
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] a, longint b);
        longint s;
        s = longint'(signed'(a)) + b;
        if (s > 64'sd2147483647)  s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    // Expected mix for one sample under the shadow registers
    function automatic t_mix mix_with_tone(logic [31:0] n, logic [31:0] l,
                                           logic [31:0] r);
        t_mix   m;
        longint tone, nyq, h;
        logic [31:0] off;
        m.l = l;
        m.r = r;
        off = n - first_sh;
        if (off >= length_sh || wave_sh == WAVE_UNUSED || rate_sh == 0) return m;
        tone = 0;
        nyq  = longint'(rate_sh) / 2;
        if (wave_sh == WAVE_SINE) begin
            tone = harmonic(1, n);
        end else begin
            for (int k = 1; k <= DEF_MAX_HARMONICS; k++) begin
                h = (wave_sh == WAVE_SQUARE) ? 2 * k - 1 : k;
                if (h * longint'(freq_sh) > nyq) break;
                tone += harmonic(h, n);
            end
        end
        m.l = sat_sum(l, tone);
        m.r = sat_sum(r, tone);
        return m;
    endfunction

    // Record accepted transactions and check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                if (fixed_exp) pending_mix.push_back(fixed_mix);
                else pending_mix.push_back(mix_with_tone(i_sample_index, i_left_in,
                                                         i_right_in));
            end
            if (o_valid) begin
                if (pending_mix.size() == 0) begin
                    $display("%0t: unexpected result %h %h", $time, o_left_out,
                             o_right_out);
                    errors++;
                end else begin
                    t_mix e;
                    e = pending_mix.pop_front();
                    if (o_left_out !== e.l) begin
                        $display("%0t: left_out expected %h actual %h", $time, e.l,
                                 o_left_out);
                        errors++;
                    end
                    if (o_right_out !== e.r) begin
                        $display("%0t: right_out expected %h actual %h", $time, e.r,
                                 o_right_out);
                        errors++;
                    end
                end
            end
        end
    end

    // Cycle guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Hold start low, then drain until nothing is pending
    task automatic settle();
        @(posedge i_clk);
        start <= 1'b0;
        wait (pending_mix.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            CFG_WAVEFORM:     wave_sh   = val[1:0];
            CFG_TONE_FREQ:    freq_sh   = val[15:0];
            CFG_SAMPLE_RATE:  rate_sh   = val[17:0];
            CFG_AMPLITUDE:    amp_sh    = val[23:0];
            CFG_FIRST_SAMPLE: first_sh  = val;
            CFG_TONE_LENGTH:  length_sh = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Drive one sample and return at the edge that accepts its transaction
    task automatic send(logic [31:0] n, logic [31:0] l, logic [31:0] r, bit typed,
                        t_mix m, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_sample_index <= n;
        i_left_in      <= l;
        i_right_in     <= r;
        fixed_exp      <= typed;
        fixed_mix      <= m;
        // sample busy away from the rising edge
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    function automatic t_row cfg_row(logic [2:0] idx, logic [31:0] val);
        t_row w;
        w = '{kind: ROW_CFG, idx: idx, val: val, default: '0};
        return w;
    endfunction

    function automatic t_row item_row(logic [31:0] n, logic [31:0] l, logic [31:0] r);
        t_row w;
        w = '{kind: ROW_ITEM, n: n, l: l, r: r, default: '0};
        return w;
    endfunction

    function automatic t_row pass_row(logic [31:0] n, logic [31:0] l, logic [31:0] r);
        t_row w;
        w = '{kind: ROW_ITEM, n: n, l: l, r: r, typed: 1'b1, el: l, er: r,
              default: '0};
        return w;
    endfunction

    function automatic logic [31:0] rand_mix();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFFFFFF - $urandom_range(0, 3000000);
            1:       return 32'h80000000 + $urandom_range(0, 3000000);
            2:       return $urandom_range(0, 4000000) - 2000000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_mix        m;
        logic [31:0] n, span;
        bit          calm;
        int          hmax;

        for (int k = 0; k <= ROM_LEN; k++) quarter_sine[k] = sine_entry(k);
        wave_sh   = WAVE_SINE;
        freq_sh   = RST_TONE_FREQ;
        rate_sh   = RST_SAMPLE_RATE;
        amp_sh    = RST_AMPLITUDE;
        first_sh  = '0;
        length_sh = '0;

        // Reset values: empty window, every sample passes through
        directed.push_back(pass_row(32'h0, 32'h7FFFFFFF, 32'h80000000));
        directed.push_back(pass_row(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        directed.push_back(pass_row(32'd123, 32'h0, 32'hFFFFFFFF));
        // Full window, sine at reset tone; index zero has zero phase
        directed.push_back(cfg_row(CFG_TONE_LENGTH, 32'hFFFFFFFF));
        directed.push_back(pass_row(32'h0, 32'h1234, 32'hFFFF0000));
        directed.push_back(item_row(32'd12345, 32'h0, 32'h0));
        directed.push_back(item_row(32'hFFFFFFFF, 32'h55AA55AA, 32'hAA55AA55));
        // Saturation at full gain near the positive peak and its negative twin
        directed.push_back(cfg_row(CFG_AMPLITUDE, 32'h00FFFFFF));
        directed.push_back(item_row(32'd27, 32'h7FFFFFFF, 32'h80000000));
        directed.push_back(item_row(32'd82, 32'h7FFFFFFF, 32'h80000000));
        // Square and saw, including the harmonic cap at low tone
        directed.push_back(cfg_row(CFG_WAVEFORM, WAVE_SQUARE));
        directed.push_back(cfg_row(CFG_TONE_FREQ, 32'd1000));
        directed.push_back(item_row(32'd7, 32'h0, 32'h100));
        directed.push_back(cfg_row(CFG_WAVEFORM, WAVE_SAW));
        directed.push_back(item_row(32'd19, 32'h0, 32'h0));
        directed.push_back(cfg_row(CFG_TONE_FREQ, 32'd100));
        directed.push_back(item_row(32'd333, 32'hFFF00000, 32'h00100000));
        // Zero tone still walks all harmonics but adds nothing
        directed.push_back(cfg_row(CFG_TONE_FREQ, 32'd0));
        directed.push_back(pass_row(32'd999, 32'h0ABCDEF0, 32'h80000000));
        // Unused waveform code and zero sample rate pass through
        directed.push_back(cfg_row(CFG_TONE_FREQ, 32'd65535));
        directed.push_back(cfg_row(CFG_WAVEFORM, WAVE_UNUSED));
        directed.push_back(pass_row(32'd5, 32'h11111111, 32'h22222222));
        directed.push_back(cfg_row(CFG_WAVEFORM, WAVE_SINE));
        directed.push_back(cfg_row(CFG_SAMPLE_RATE, 32'd0));
        directed.push_back(pass_row(32'd5, 32'h33333333, 32'h44444444));
        // Wrapping window and rate extremes
        directed.push_back(cfg_row(CFG_SAMPLE_RATE, 32'd262143));
        directed.push_back(cfg_row(CFG_FIRST_SAMPLE, 32'hFFFFFFF0));
        directed.push_back(cfg_row(CFG_TONE_LENGTH, 32'd32));
        directed.push_back(item_row(32'hFFFFFFF0, 32'h0, 32'h0));
        directed.push_back(item_row(32'd5, 32'h0, 32'h0));
        directed.push_back(pass_row(32'd16, 32'h0, 32'h7));
        directed.push_back(pass_row(32'hFFFFFFEF, 32'h9, 32'h0));
        directed.push_back(cfg_row(CFG_SAMPLE_RATE, 32'd1));
        directed.push_back(item_row(32'd3, 32'h0, 32'h0));
        directed.push_back(cfg_row(CFG_AMPLITUDE, 32'd0));
        directed.push_back(pass_row(32'd9, 32'h7FFFFFFF, 32'h80000000));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed[i].idx, directed[i].val);
            end else begin
                m.l = directed[i].el;
                m.r = directed[i].er;
                send(directed[i].n, directed[i].l, directed[i].r, directed[i].typed,
                     m, pick_gap());
            end
        end

        // Random phases, each with a fresh register setting
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            write_reg(CFG_WAVEFORM,
                      (p % 7 == 6) ? 32'(WAVE_UNUSED) : $urandom_range(0, 2));
            case (p % 4)
                0:       write_reg(CFG_SAMPLE_RATE, 32'd262143);
                1:       write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 200));
                default: write_reg(CFG_SAMPLE_RATE, $urandom_range(8000, 262143));
            endcase
            // Keep most phases to a handful of harmonics; two run the full cap
            if (p == 3 || p == 9) hmax = 200;
            else hmax = $urandom_range(1, 8);
            if (p == 5) write_reg(CFG_TONE_FREQ, 32'd65535);
            else if (p == 3) write_reg(CFG_TONE_FREQ, 32'd0);
            else write_reg(CFG_TONE_FREQ,
                           ((rate_sh / 2) / hmax + $urandom_range(0, 3)) & 32'hFFFF);
            case (p % 3)
                0:       write_reg(CFG_AMPLITUDE, 32'h00FFFFFF);
                1:       write_reg(CFG_AMPLITUDE, $urandom & 32'h00FFFFFF);
                default: write_reg(CFG_AMPLITUDE, (p == 2) ? 32'd0 : 32'h00100000);
            endcase
            write_reg(CFG_FIRST_SAMPLE, $urandom);
            write_reg(CFG_TONE_LENGTH, (p % 5 == 0) ? 32'hFFFFFFFF : $urandom_range(1, 4000));
            calm = ($urandom_range(0, 3) == 0);
            span = (length_sh > 32'h7FFFFFFF) ? 32'hFFFFFFFF : length_sh + length_sh / 4;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (length_sh == 32'hFFFFFFFF || $urandom_range(0, 9) == 0) n = $urandom;
                else n = first_sh + $urandom_range(0, span);
                send(n, rand_mix(), rand_mix(), 1'b0, m, calm ? 0 : pick_gap());
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
